FILE: rtl/bres_pkg.sv
// Shared widths and codes for the line rasterizer.
`default_nettype none
package bres_pkg;

  // Coordinate width; the delta, error, data and compare widths below follow from it.
  localparam int COORD_BITS  = 16;
  localparam int COLOR_BITS  = 24;
  localparam int SCREEN_BITS = 13;

  // Error walk widths: |dx| needs one bit more than a coordinate,
  // the error term two more again to carry its sign and headroom.
  localparam int DELTA_BITS  = COORD_BITS + 1;
  localparam int NDY_BITS    = COORD_BITS + 2;
  localparam int ERR_BITS    = COORD_BITS + 3;

  localparam int IN_RAW_BITS   = 4 * COORD_BITS + COLOR_BITS;
  localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_BITS  = 2 * COORD_BITS + COLOR_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  // Clipping compares a non-negative coordinate against a screen size.
  localparam int CMP_BITS = (COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS;

  localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = SCREEN_BITS'(640);
  localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = SCREEN_BITS'(480);

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_index_t;

endpackage
`default_nettype wire

FILE: rtl/bresenham_line_rasterizer_top.sv
// Top level of the all-octant Bresenham line rasterizer.
`default_nettype none
//
//  channel  dir  handshake                     word contents
//  -------  ---  ----------------------------  ------------------------------------
//  s_axis   in   s_axis_tvalid/s_axis_tready   tuser: action; tdata: endpoints, colour
//  m_axis   out  m_axis_tvalid/m_axis_tready   tuser: on_screen; tlast: end pixel;
//                                              tdata: pixel x, y, colour
//  cfg      in   cfg_valid/cfg_ready           cfg_index, cfg_data (screen size)
//
//  One word per cycle while s_axis_tready is high. A start word loads the line and
//  emits nothing; a step word on a loaded line emits one pixel, registered on m_axis
//  in the next cycle, at the cost of a single pass through the error update (two
//  compares, one three-way add). Synchronous active-high reset: idle, no line loaded,
//  screen 640 x 480. s_axis_tready drops only while a pixel sits on m_axis with
//  m_axis_tready low. cfg_ready is always high.
//
module bresenham_line_rasterizer_top (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // tuser: [0] action (0 start, 1 step)
  input  wire logic                                    s_axis_tvalid,
  output      logic                                    s_axis_tready,
  // tdata: start_x, start_y, end_x, end_y, line_color (lowest first)
  input  wire logic [bres_pkg::IN_DATA_BITS-1:0]       s_axis_tdata,
  input  wire logic                                    s_axis_tuser,
  output      logic                                    m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  // tdata: pixel_x, pixel_y, pixel_color (lowest first)
  output      logic [bres_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata,
  // tuser: [0] on_screen
  output      logic                                    m_axis_tuser,
  output      logic                                    m_axis_tlast,
  input  wire logic                                    cfg_valid,
  output      logic                                    cfg_ready,
  input  wire logic                                    cfg_index,
  input  wire logic [bres_pkg::SCREEN_BITS-1:0]        cfg_data
);
  import bres_pkg::*;

  localparam int CW = COORD_BITS;

  // Configuration
  logic [SCREEN_BITS-1:0] screen_width;
  logic [SCREEN_BITS-1:0] screen_height;

  // Line state
  logic [CW-1:0]         cur_x, cur_x_next;
  logic [CW-1:0]         cur_y, cur_y_next;
  logic [CW-1:0]         goal_x, goal_y;
  logic [DELTA_BITS-1:0] delta_x;      // |dx|, unsigned
  logic [NDY_BITS-1:0]   neg_delta_y;  // -|dy|, two's complement
  logic                  step_x_neg, step_y_neg;
  logic [ERR_BITS-1:0]   error_term, error_next;
  logic [COLOR_BITS-1:0] held_color;
  logic                  busy;

  // Input word fields
  logic [CW-1:0]         in_x1, in_y1, in_x2, in_y2;
  logic [COLOR_BITS-1:0] in_color;
  logic                  accept, is_start, is_step;

  // Start-time set-up
  logic [CW:0]           dx_full, dy_full;
  logic [DELTA_BITS-1:0] abs_dx;
  logic [NDY_BITS-1:0]   ndy_init;
  logic [ERR_BITS-1:0]   err_init;

  // Step-time walk
  logic signed [ERR_BITS:0] e2, ndy_cmp, dx_cmp;
  logic                     move_x, move_y, fin, on_scr;
  logic [ERR_BITS-1:0]      add_x, add_y;

  assign cfg_ready     = 1'b1;
  // Output register parts the two sides: refill while it drains.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_start      = accept && (action_t'(s_axis_tuser) == ACT_START);
  assign is_step       = accept && (action_t'(s_axis_tuser) == ACT_STEP) && busy;

  assign in_x1    = s_axis_tdata[CW-1:0];
  assign in_y1    = s_axis_tdata[2*CW-1:CW];
  assign in_x2    = s_axis_tdata[3*CW-1:2*CW];
  assign in_y2    = s_axis_tdata[4*CW-1:3*CW];
  assign in_color = s_axis_tdata[4*CW+COLOR_BITS-1:4*CW];

  // Set-up: |dx|, -|dy| and the initial error |dx| - |dy|.
  always_comb begin
    dx_full  = {in_x2[CW-1], in_x2} - {in_x1[CW-1], in_x1};
    dy_full  = {in_y2[CW-1], in_y2} - {in_y1[CW-1], in_y1};
    abs_dx   = DELTA_BITS'(dx_full[CW] ? (~dx_full + 1'b1) : dx_full);
    ndy_init = dy_full[CW] ? NDY_BITS'($signed(dy_full))
                           : NDY_BITS'($signed(~dy_full + 1'b1));
    err_init = ERR_BITS'(abs_dx) + ERR_BITS'($signed(ndy_init));
  end

  // One pixel of the error walk.
  always_comb begin
    e2      = $signed({error_term, 1'b0});
    ndy_cmp = (ERR_BITS+1)'($signed(neg_delta_y));
    dx_cmp  = $signed((ERR_BITS+1)'(delta_x));
    move_x  = (e2 >= ndy_cmp);
    move_y  = (e2 <= dx_cmp);
    add_x   = move_x ? ERR_BITS'($signed(neg_delta_y)) : '0;
    add_y   = move_y ? ERR_BITS'(delta_x) : '0;
    error_next = error_term + add_x + add_y;
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    if (move_x) begin
      cur_x_next = step_x_neg ? (cur_x - 1'b1) : (cur_x + 1'b1);
    end
    if (move_y) begin
      cur_y_next = step_y_neg ? (cur_y - 1'b1) : (cur_y + 1'b1);
    end
    fin    = (cur_x == goal_x) && (cur_y == goal_y);
    on_scr = !cur_x[CW-1] && !cur_y[CW-1]
             && (CMP_BITS'(cur_x) < CMP_BITS'(screen_width))
             && (CMP_BITS'(cur_y) < CMP_BITS'(screen_height));
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      cur_x       <= '0;
      cur_y       <= '0;
      goal_x      <= '0;
      goal_y      <= '0;
      delta_x     <= '0;
      neg_delta_y <= '0;
      step_x_neg  <= 1'b0;
      step_y_neg  <= 1'b0;
      error_term  <= '0;
      held_color  <= '0;
    end else if (is_start) begin
      busy        <= 1'b1;
      cur_x       <= in_x1;
      cur_y       <= in_y1;
      goal_x      <= in_x2;
      goal_y      <= in_y2;
      delta_x     <= abs_dx;
      neg_delta_y <= ndy_init;
      step_x_neg  <= dx_full[CW];
      step_y_neg  <= dy_full[CW];
      error_term  <= err_init;
      held_color  <= in_color;
    end else if (is_step) begin
      if (fin) begin
        busy <= 1'b0;
      end else begin
        cur_x      <= cur_x_next;
        cur_y      <= cur_y_next;
        error_term <= error_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (is_step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_step) begin
      m_axis_tdata <= OUT_DATA_BITS'({held_color, cur_y, cur_x});
      m_axis_tuser <= on_scr;
      m_axis_tlast <= fin;
    end
  end

endmodule
`default_nettype wire

FILE: bench/tb_bresenham_line_rasterizer_top.sv
// Self-checking bench for the Bresenham line rasterizer: directed lines, screen sizes, random walks.
module tb_bresenham_line_rasterizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bres_pkg::*;

  localparam int CLK_PERIOD  = 20;
  // Watchdog bound on run length; it leaves ample room above the slowest correct run.
  localparam int CYCLE_LIMIT = 500000;
  // A pixel is registered on m_axis in the cycle after its step word; the settle wait covers it.
  localparam int SETTLE_CYCLES = 4;

  // One emitted pixel as the checker sees it.
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0] colour;
    logic                  on_screen;
    logic                  fin;
  } pixel_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  // tdata: start_x, start_y, end_x, end_y, line_color (lowest first)
  logic [IN_DATA_BITS-1:0]  s_axis_tdata;
  // tuser: [0] action
  logic                     s_axis_tuser;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  // tdata: pixel_x, pixel_y, pixel_color (lowest first)
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  // tuser: [0] on_screen
  logic                     m_axis_tuser;
  logic                     m_axis_tlast;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic                     cfg_index;
  logic [SCREEN_BITS-1:0]   cfg_data;

  bresenham_line_rasterizer_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Line walker: own copy of the pen state and screen size, advanced on every
  // accepted word. Plain ints are wide enough for |dx| and twice the error.
  // ---------------------------------------------------------------------------
  int               pen_x, pen_y, end_px, end_py;
  int               run_x;       // |dx|
  int               rise_neg;    // -|dy|
  int               err_acc;
  bit               x_backward, y_backward;
  bit               drawing;
  logic [COLOR_BITS-1:0]  pen_colour;
  logic [SCREEN_BITS-1:0] scr_width, scr_height;

  pixel_t expected_pixels[$];

  int  mismatches;
  int  counted_words;
  int  cycles;
  bit  gaps_on;
  bit  stalls_on;

  function automatic void reset_pen();
    pen_x      = 0;
    pen_y      = 0;
    end_px     = 0;
    end_py     = 0;
    run_x      = 0;
    rise_neg   = 0;
    err_acc    = 0;
    x_backward = 1'b0;
    y_backward = 1'b0;
    drawing    = 1'b0;
    pen_colour = '0;
    scr_width  = WIDTH_RESET;
    scr_height = HEIGHT_RESET;
  endfunction

  // Applies one accepted word; a step on an active line queues the pixel.
  function automatic void rasterize_word(action_t act, logic signed [COORD_BITS-1:0] x1,
                                         logic signed [COORD_BITS-1:0] y1,
                                         logic signed [COORD_BITS-1:0] x2,
                                         logic signed [COORD_BITS-1:0] y2,
                                         logic [COLOR_BITS-1:0] colour);
    int     ddx;
    int     ddy;
    int     e2;
    pixel_t pix;
    if (act == ACT_START) begin
      ddx        = int'(x2) - int'(x1);
      ddy        = int'(y2) - int'(y1);
      pen_x      = int'(x1);
      pen_y      = int'(y1);
      end_px     = int'(x2);
      end_py     = int'(y2);
      run_x      = (ddx < 0) ? -ddx : ddx;
      rise_neg   = (ddy < 0) ? ddy : -ddy;
      x_backward = (ddx < 0);
      y_backward = (ddy < 0);
      err_acc    = run_x + rise_neg;
      pen_colour = colour;
      drawing    = 1'b1;
      return;
    end
    if (!drawing) return;   // step with no line loaded: nothing comes out
    pix.x         = pen_x[COORD_BITS-1:0];
    pix.y         = pen_y[COORD_BITS-1:0];
    pix.colour    = pen_colour;
    pix.on_screen = (pen_x >= 0) && (pen_x < int'(scr_width)) &&
                    (pen_y >= 0) && (pen_y < int'(scr_height));
    pix.fin       = (pen_x == end_px) && (pen_y == end_py);
    expected_pixels.push_back(pix);
    if (pix.fin) begin
      drawing = 1'b0;
    end else begin
      e2 = 2 * err_acc;
      if (e2 >= rise_neg) begin
        err_acc += rise_neg;
        pen_x   += x_backward ? -1 : 1;
      end
      if (e2 <= run_x) begin
        err_acc += run_x;
        pen_y   += y_backward ? -1 : 1;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel checker: every handshake on m_axis is matched against the oldest
  // queued pixel, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d", $signed(m_axis_tdata[15:0]),
               $signed(m_axis_tdata[31:16]));
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (m_axis_tdata[15:0] !== want.x) begin
          $error("pixel_x: expected %0d, got %0d", $signed(want.x),
                 $signed(m_axis_tdata[15:0]));
          mismatches++;
        end
        if (m_axis_tdata[31:16] !== want.y) begin
          $error("pixel_y: expected %0d, got %0d", $signed(want.y),
                 $signed(m_axis_tdata[31:16]));
          mismatches++;
        end
        if (m_axis_tdata[55:32] !== want.colour) begin
          $error("pixel_color: expected %06h, got %06h", want.colour, m_axis_tdata[55:32]);
          mismatches++;
        end
        if (m_axis_tuser !== want.on_screen) begin
          $error("on_screen: expected %0b, got %0b", want.on_screen, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tlast !== want.fin) begin
          $error("last: expected %0b, got %0b", want.fin, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver back-pressure: random stall bursts while enabled.
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Inputs move on the falling edge; handshakes are seen on the rising
  // edge. tvalid stays high between back-to-back words.
  // ---------------------------------------------------------------------------
  task automatic send_word(action_t act, logic signed [COORD_BITS-1:0] x1,
                           logic signed [COORD_BITS-1:0] y1,
                           logic signed [COORD_BITS-1:0] x2,
                           logic signed [COORD_BITS-1:0] y2,
                           logic [COLOR_BITS-1:0] colour);
    if (act == ACT_START || drawing) counted_words++;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {colour, y2, x2, y1, x1};
    do @(posedge clk); while (!s_axis_tready);
    rasterize_word(act, x1, y1, x2, y2, colour);
  endtask

  // Step word; the endpoint fields are don't-care, so fill them with noise.
  task automatic step_pen();
    send_word(ACT_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
              COORD_BITS'($urandom), COORD_BITS'($urandom), COLOR_BITS'($urandom));
  endtask

  task automatic walk_to_end();
    do step_pen(); while (drawing);
  endtask

  task automatic draw_line(int x1, int y1, int x2, int y2, logic [COLOR_BITS-1:0] colour);
    send_word(ACT_START, COORD_BITS'(x1), COORD_BITS'(y1), COORD_BITS'(x2),
              COORD_BITS'(y2), colour);
    walk_to_end();
  endtask

  // Sender holds off until every queued pixel has come out.
  task automatic hold_until_drawn(bit settle);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes only happen with the pipe empty.
  task automatic write_screen(reg_index_t idx, logic [SCREEN_BITS-1:0] value);
    hold_until_drawn(1'b1);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SCREEN_WIDTH) scr_width = value;
    else                         scr_height = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_screen(logic [SCREEN_BITS-1:0] w, logic [SCREEN_BITS-1:0] h);
    write_screen(REG_SCREEN_WIDTH, w);
    write_screen(REG_SCREEN_HEIGHT, h);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Step before any line is loaded: must produce nothing.
  task automatic test_idle_step();
    step_pen();
  endtask

  // Line of one point at the coordinate extremes, then a step past its end.
  task automatic test_single_point();
    draw_line(-32768, 32767, -32768, 32767, 24'h000001);
    step_pen();
  endtask

  // Vertical line walked upward.
  task automatic test_vertical_up();
    draw_line(3, 2, 3, 0, 24'h80FF00);
  endtask

  // Full-span diagonal: one pixel, a pause with the line part drawn, a second pixel,
  // then abandoned by a new start at another corner.
  task automatic test_extreme_span();
    send_word(ACT_START, COORD_BITS'(-32768), COORD_BITS'(-32768), COORD_BITS'(32767),
              COORD_BITS'(32767), 24'hFFFFFF);
    step_pen();
    hold_until_drawn(1'b0);
    step_pen();
    draw_line(32767, -32768, 32765, -32767, 24'h000000);
  endtask

  // Screen size extremes: zero, register maximum, one, nominal maximum.
  task automatic test_screen_limits();
    set_screen(13'd0, 13'd0);
    draw_line(0, 0, 1, 0, 24'h123456);
    set_screen(13'd8191, 13'd8191);
    draw_line(8190, 8190, 8191, 8191, 24'hA5A5A5);
    set_screen(13'd1, 13'd1);
    draw_line(-1, -1, 1, 1, 24'h5A5A5A);
    set_screen(13'd4096, 13'd4096);
    draw_line(4095, 4094, 4096, 4096, 24'hFEDCBA);
  endtask

  function automatic int clamp_coord(int v);
    if (v > 32767)  return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic [SCREEN_BITS-1:0] pick_size();
    case ($urandom_range(0, 5))
      0:       return SCREEN_BITS'($urandom_range(1, 4096));
      1, 2:    return SCREEN_BITS'($urandom_range(4, 48));
      3:       return 13'd4096;
      4:       return SCREEN_BITS'($urandom_range(4097, 8191));
      default: return SCREEN_BITS'($urandom_range(0, 3));
    endcase
  endfunction

  // Mostly complete short lines, around the screen or anywhere in range, with abandoned
  // lines, stray steps and full-range noise mixed in.
  task automatic test_random_lines(int quota);
    int stop_at;
    int x1, y1, x2, y2, reach, steps;
    stop_at = counted_words + quota;
    while (counted_words < stop_at) begin
      case ($urandom_range(0, 9))
        0: begin
          send_word(ACT_START, COORD_BITS'($urandom), COORD_BITS'($urandom),
                    COORD_BITS'($urandom), COORD_BITS'($urandom), COLOR_BITS'($urandom));
          repeat ($urandom_range(1, 6)) step_pen();
        end
        1: repeat ($urandom_range(1, 3)) step_pen();
        default: begin
          reach = ($urandom_range(0, 9) == 0) ? 80 : 12;
          if ($urandom_range(0, 1)) begin
            x1 = int'($urandom_range(0, int'(scr_width) + 16)) - 8;
            y1 = int'($urandom_range(0, int'(scr_height) + 16)) - 8;
          end else begin
            x1 = clamp_coord(int'($urandom_range(0, 65535)) - 32768);
            y1 = clamp_coord(int'($urandom_range(0, 65535)) - 32768);
          end
          x2 = clamp_coord(x1 + int'($urandom_range(0, 2 * reach)) - reach);
          y2 = clamp_coord(y1 + int'($urandom_range(0, 2 * reach)) - reach);
          send_word(ACT_START, COORD_BITS'(x1), COORD_BITS'(y1), COORD_BITS'(x2),
                    COORD_BITS'(y2), COLOR_BITS'($urandom));
          if ($urandom_range(0, 7) == 0) begin
            // abandon part way; next start replaces it
            steps = $urandom_range(0, 5);
            repeat (steps) if (drawing) step_pen();
          end else begin
            walk_to_end();
            if ($urandom_range(0, 5) == 0) step_pen();
          end
          if ($urandom_range(0, 29) == 0) hold_until_drawn(1'b0);
        end
      endcase
    end
  endtask

  // Several screen settings; the last phase runs with no sender gaps and no receiver stalls.
  task automatic test_random_phases();
    for (int phase = 0; phase < 6; phase++) begin
      set_screen(pick_size(), pick_size());
      gaps_on   = (phase < 5);
      stalls_on = (phase < 5);
      test_random_lines((phase < 5) ? 300 : 250);
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_SCREEN_WIDTH;
    cfg_data      = '0;
    mismatches    = 0;
    counted_words = 0;
    cycles        = 0;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;
    reset_pen();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_step();
    test_single_point();
    test_vertical_up();
    test_extreme_span();
    test_screen_limits();
    test_random_phases();

    // Drain, let any late pixel show up, then judge.
    hold_until_drawn(1'b1);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $error("%0d pixels never emitted", expected_pixels.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
